/* hw/rtl/rle_byte_unpacker_top_defines.svh */
// ---------------------------------------------------------------------------
// RLE byte unpacker assertion macros
// Shared concurrent assertion forms used by the unpacker checker.
// ---------------------------------------------------------------------------
`ifndef RLE_BYTE_UNPACKER_TOP_DEFINES_SVH
`define RLE_BYTE_UNPACKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/rbu_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLE byte unpacker package
// Widths, constants and controller/datapath types of the unpacker.
// ---------------------------------------------------------------------------
package rbu_pkg;

	localparam int unsigned BYTES_PER_RESULT_DEF = 4;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OUT_BYTES = 4;
	localparam int unsigned DATA_W   = BYTE_W * OUT_BYTES;
	localparam int unsigned COUNT_W  = 3;
	localparam int unsigned LEN_W    = 24;
	localparam int unsigned PROD_W   = 25;
	localparam int unsigned RUN_W    = 8;
	localparam int unsigned REPEAT_BASE = 257;

	typedef enum logic [1:0] {
		ST_TOKEN   = 2'd0,
		ST_FILL    = 2'd1,
		ST_LITERAL = 2'd2,
		ST_EXPAND  = 2'd3
	} rbu_state_t;

	typedef struct packed {
		logic load_token;
		logic load_fill;
		logic emit_literal;
		logic emit_chunk;
	} rbu_cmd_t;

	typedef struct packed {
		logic len_zero;
		logic out_free;
		logic is_repeat;
		logic lit_last;
		logic chunk_last;
	} rbu_sts_t;

endpackage

/* hw/rtl/rbu_byte_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Packed byte channel
// Valid/ready channel carrying one byte of the packed stream.
// ---------------------------------------------------------------------------
interface rbu_byte_if import rbu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

/* hw/rtl/rbu_word_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decoded word channel
// Valid/ready channel carrying up to four decoded bytes and their flags.
// ---------------------------------------------------------------------------
interface rbu_word_if import rbu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  out_data;
	logic [COUNT_W-1:0] out_count;
	logic               last_of_run;
	logic               frame_done;

	modport source (output valid, output out_data, output out_count, output last_of_run,
		output frame_done, input ready);
	modport sink (input valid, input out_data, input out_count, input last_of_run,
		input frame_done, output ready);
endinterface

/* hw/rtl/rbu_cfg_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes the frame length register.
// ---------------------------------------------------------------------------
interface rbu_cfg_if import rbu_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] frame_length;

	modport source (output valid, output frame_length, input ready);
	modport sink (input valid, input frame_length, output ready);
endinterface

/* hw/rtl/rbu_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLE byte unpacker controller
// Tracks the decode phase and issues load and emit commands to the datapath.
// ---------------------------------------------------------------------------
module rbu_ctrl import rbu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rbu_sts_t sts,
	output rbu_cmd_t cmd
);

	rbu_state_t state_q;
	rbu_state_t state_next;
	logic       take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TOKEN;
		end else begin
			state_q <= state_next;
		end
	end

	// A zero frame length drops every byte without touching the phase.
	assign take = in_valid && in_ready && !sts.len_zero;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_TOKEN: begin
				if (take) begin
					state_next = sts.is_repeat ? ST_FILL : ST_LITERAL;
				end
			end
			ST_FILL: begin
				if (take) begin
					state_next = ST_EXPAND;
				end
			end
			ST_LITERAL: begin
				if (take && sts.lit_last) begin
					state_next = ST_TOKEN;
				end
			end
			ST_EXPAND: begin
				if (sts.out_free && sts.chunk_last) begin
					state_next = ST_TOKEN;
				end
			end
			default: begin
				state_next = ST_TOKEN;
			end
		endcase
	end

	always_comb begin
		in_ready = sts.len_zero;
		cmd      = '0;
		case (state_q)
			ST_TOKEN: begin
				in_ready       = 1'b1;
				cmd.load_token = take;
			end
			ST_FILL: begin
				in_ready      = 1'b1;
				cmd.load_fill = take;
			end
			ST_LITERAL: begin
				in_ready         = sts.len_zero || sts.out_free;
				cmd.emit_literal = take;
			end
			ST_EXPAND: begin
				cmd.emit_chunk = sts.out_free;
			end
			default: begin
				in_ready = sts.len_zero;
			end
		endcase
	end

endmodule

/* hw/rtl/rbu_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLE byte unpacker datapath
// Run and literal counters, frame byte counter, and the output register.
// ---------------------------------------------------------------------------
module rbu_datapath import rbu_pkg::*; #(
	parameter int unsigned BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] in_byte,
	input  rbu_cmd_t          cmd,
	output rbu_sts_t          sts,
	rbu_cfg_if.sink           cfg,
	rbu_word_if.source        decoded
);

	localparam logic [RUN_W-1:0] ChunkMax = RUN_W'(BYTES_PER_RESULT);

	logic [LEN_W-1:0]   frame_length_q;
	logic [PROD_W-1:0]  produced_q;
	logic [RUN_W-1:0]   left_q;
	logic [RUN_W-1:0]   lit_q;
	logic               done_q;
	logic [BYTE_W-1:0]  fill_byte_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               last_q;
	logic               frame_done_q;

	logic [RUN_W-1:0]   chunk_n;
	logic [RUN_W-1:0]   left_rem;
	logic [DATA_W-1:0]  chunk_data;
	logic [RUN_W-1:0]   addend;
	logic [PROD_W-1:0]  sum;
	logic               reached;
	logic [RUN_W-1:0]   lit_next;
	logic [RUN_W:0]     repeat_wide;
	logic               out_free;

	assign out_free = !out_valid_q || decoded.ready;

	assign chunk_n  = (left_q < ChunkMax) ? left_q : ChunkMax;
	assign left_rem = left_q - chunk_n;

	always_comb begin
		chunk_data = '0;
		for (int i = 0; i < OUT_BYTES; i++) begin
			if (RUN_W'(i) < chunk_n) begin
				chunk_data[BYTE_W*i +: BYTE_W] = fill_byte_q;
			end
		end
	end

	// One adder serves both the run total and a single literal byte.
	assign addend   = cmd.load_fill ? left_q : RUN_W'(1);
	assign sum      = produced_q + PROD_W'(addend);
	assign reached  = sum >= PROD_W'(frame_length_q);
	assign lit_next = (lit_q != '0) ? lit_q - RUN_W'(1) : '0;

	assign repeat_wide = (RUN_W + 1)'(REPEAT_BASE) - {1'b0, in_byte};

	assign sts.len_zero   = (frame_length_q == '0);
	assign sts.out_free   = out_free;
	assign sts.is_repeat  = in_byte[BYTE_W-1];
	assign sts.lit_last   = (lit_next == '0);
	assign sts.chunk_last = (left_rem == '0);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= '0;
			produced_q     <= '0;
			left_q         <= '0;
			lit_q          <= '0;
			done_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				frame_length_q <= cfg.frame_length;
			end
			if (cmd.load_token) begin
				if (in_byte[BYTE_W-1]) begin
					left_q <= repeat_wide[RUN_W-1:0];
				end else begin
					lit_q <= RUN_W'(in_byte) + RUN_W'(1);
				end
			end
			if (cmd.load_fill) begin
				done_q     <= reached;
				produced_q <= reached ? '0 : sum;
			end
			if (cmd.emit_literal) begin
				lit_q      <= lit_next;
				produced_q <= (sts.lit_last && reached) ? '0 : sum;
			end
			if (cmd.emit_chunk) begin
				left_q <= left_rem;
			end
			if (cmd.emit_literal || cmd.emit_chunk) begin
				out_valid_q <= 1'b1;
			end else if (decoded.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_fill) begin
			fill_byte_q <= in_byte;
		end
		if (cmd.emit_literal) begin
			out_data_q   <= DATA_W'(in_byte);
			out_count_q  <= COUNT_W'(1);
			last_q       <= 1'b1;
			frame_done_q <= sts.lit_last && reached;
		end else if (cmd.emit_chunk) begin
			out_data_q   <= chunk_data;
			out_count_q  <= chunk_n[COUNT_W-1:0];
			last_q       <= (left_rem == '0);
			frame_done_q <= (left_rem == '0) && done_q;
		end
	end

	assign decoded.valid       = out_valid_q;
	assign decoded.out_data    = out_data_q;
	assign decoded.out_count   = out_count_q;
	assign decoded.last_of_run = last_q;
	assign decoded.frame_done  = frame_done_q;

endmodule

/* hw/rtl/rle_byte_unpacker_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLE byte unpacker
// PackBits-style run-length decoder with packed multi-byte results.
// ---------------------------------------------------------------------------
// Token bytes are taken at one per cycle, and literal bytes likewise while
// the output register is free; a literal yields a one-byte result in the
// output register, which is refilled in the same cycle that its current
// result is taken. Once the fill byte is loaded, the run is expanded at one
// result per cycle, ceil(copies / BYTES_PER_RESULT) results, paced by output
// ready; the input is held off during expansion. With a frame length of zero
// every byte is accepted and dropped. Configuration writes are always taken.
module rle_byte_unpacker_top import rbu_pkg::*; #(
	parameter int unsigned BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
	input logic      clk,
	input logic      arst_n,
	rbu_byte_if.sink   packed_stream,
	rbu_word_if.source decoded,
	rbu_cfg_if.sink    cfg
);

	rbu_cmd_t cmd;
	rbu_sts_t sts;
	logic     in_ready;

	assign packed_stream.ready = in_ready;

	rbu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (packed_stream.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rbu_datapath #(
		.BYTES_PER_RESULT (BYTES_PER_RESULT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (packed_stream.in_byte),
		.cmd     (cmd),
		.sts     (sts),
		.cfg     (cfg),
		.decoded (decoded)
	);

endmodule

/* hw/rtl/rbu_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLE byte unpacker checker
// Port-level assertions on the decoded output channel, bound to the top.
// ---------------------------------------------------------------------------
`include "rle_byte_unpacker_top_defines.svh"

module rbu_checker import rbu_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DATA_W-1:0]  out_data,
	input logic [COUNT_W-1:0] out_count,
	input logic               last_of_run,
	input logic               frame_done
);

	logic out_stall;
	assign out_stall = out_valid && !out_ready;

	// Only the final result of a token can close a frame.
	`RBU_ASSERT_IMPL(a_done_on_last, clk, arst_n, out_valid && frame_done, last_of_run)
	// A single-byte result carries zeros in its unused upper bytes.
	`RBU_ASSERT_IMPL(a_single_byte_clean, clk, arst_n, out_valid && out_count == COUNT_W'(1), out_data[DATA_W-1:BYTE_W] == '0)
	`RBU_ASSERT_NEXT(a_valid_holds, clk, arst_n, out_stall, out_valid)
	`RBU_ASSERT_NEXT(a_payload_holds, clk, arst_n, out_stall, $stable(out_data) && $stable(out_count) && $stable(last_of_run) && $stable(frame_done))

endmodule

bind rle_byte_unpacker_top rbu_checker u_rbu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (decoded.valid),
	.out_ready   (decoded.ready),
	.out_data    (decoded.out_data),
	.out_count   (decoded.out_count),
	.last_of_run (decoded.last_of_run),
	.frame_done  (decoded.frame_done)
);
